// File: src/cls_pkg.sv
// Shared types and codes of the CPU lifecycle state table.
`default_nettype none
package cls_pkg;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_START,
    FSM_SCAN,
    FSM_EXEC,
    FSM_SNAP
  } fsm_t;

  localparam logic [3:0] CMD_APPEND   = 4'd0;
  localparam logic [3:0] CMD_FINISH   = 4'd1;
  localparam logic [3:0] CMD_RESERVE  = 4'd2;
  localparam logic [3:0] CMD_FAIL_RT  = 4'd3;
  localparam logic [3:0] CMD_PUBLISH  = 4'd4;
  localparam logic [3:0] CMD_BEGIN    = 4'd5;
  localparam logic [3:0] CMD_FAIL_ST  = 4'd6;
  localparam logic [3:0] CMD_ONLINE   = 4'd7;
  localparam logic [3:0] CMD_BY_ID    = 4'd8;
  localparam logic [3:0] CMD_BY_HW    = 4'd9;
  localparam logic [3:0] CMD_SNAPSHOT = 4'd10;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_TOPO     = 3'd1;
  localparam logic [2:0] STS_DUP      = 3'd2;
  localparam logic [2:0] STS_DONE     = 3'd3;
  localparam logic [2:0] STS_STATE    = 3'd4;
  localparam logic [2:0] STS_ALLOC    = 3'd5;
  localparam logic [2:0] STS_REJ      = 3'd6;
  localparam logic [2:0] STS_NOTFOUND = 3'd7;

  localparam logic [2:0] LC_POSSIBLE = 3'd0;
  localparam logic [2:0] LC_PRESENT  = 3'd1;
  localparam logic [2:0] LC_PREPARED = 3'd2;
  localparam logic [2:0] LC_STARTING = 3'd3;
  localparam logic [2:0] LC_ONLINE   = 3'd4;
  localparam logic [2:0] LC_FAILED   = 3'd5;

  localparam logic [1:0] AV_ENABLED  = 2'd0;
  localparam logic [1:0] AV_DISABLED = 2'd1;
  localparam logic [1:0] AV_FAILED   = 2'd2;
  localparam logic [1:0] AV_UNKNOWN  = 2'd3;

  localparam logic [2:0] FC_NONE     = 3'd0;
  localparam logic [2:0] FC_FIRMWARE = 3'd1;
  localparam logic [2:0] FC_ALLOC    = 3'd2;

  localparam logic [2:0] LAST_BEAT   = 3'd5;

endpackage
`default_nettype wire

// File: src/cpu_lifecycle_state_table.sv
// Append and lookup by hardware id walk the record memory one entry a cycle;
// single-record commands do not walk it.
// Snapshot: a walk of the record memory, then six result beats.
// One item at a time; the next is taken once the current result is registered.
// Synchronous reset empties the table and clears build state; no clearing pass.
`default_nettype none
module cpu_lifecycle_state_table #(
  parameter int MAX_CPUS   = 64,
  parameter int HW_ID_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_command,
  input  wire logic [5:0]  in_logical_id,
  input  wire logic [31:0] in_hardware_id,
  input  wire logic [1:0]  in_availability,
  input  wire logic [2:0]  in_failure_code,
  input  wire logic        in_alloc_ok,
  input  wire logic        in_runtime_ready,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [5:0]       out_logical_id_res,
  output logic [31:0]      out_hardware_id_res,
  output logic [2:0]       out_cpu_state,
  output logic [2:0]       out_failure_code_res,
  output logic [1:0]       out_availability_res,
  output logic             out_runtime_visible,
  output logic [6:0]       out_state_count,
  output logic             out_last
);

  localparam int HWS   = (HW_ID_BITS < 32) ? HW_ID_BITS : 32;
  localparam int CW    = $clog2(MAX_CPUS + 1);
  localparam int AW    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int REC_W = HWS + 9;

  cls_pkg::fsm_t state_r, state_nxt;

  logic [3:0]     cmd_r;
  logic [5:0]     lid_r;
  logic [HWS-1:0] hw_r;
  logic [1:0]     av_r;
  logic [2:0]     fc_r;
  logic           alloc_r, ready_r;

  logic [6:0]     cc_r;
  logic [5:0]     boot_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           done_r, done_nxt;

  logic [CW-1:0]  iss_r, iss_nxt, chk_r, idx_r, idx_nxt;
  logic           pend_r, pend_nxt, found_r, found_nxt;
  logic [2:0]     k_r, k_nxt;
  logic [CW-1:0]  snap_r [6];
  logic [CW-1:0]  snap_nxt [6];

  logic             rd_en, we;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [REC_W-1:0] rd_data, wr_data;

  logic           out_valid_r;
  logic           out_free, in_acc;
  logic           topo, full, id_ok, start_scan, scan_issue, scan_match, scan_end;

  logic [HWS-1:0] r_hw;
  logic [1:0]     r_av;
  logic [2:0]     r_life, r_fail;
  logic           r_rt;

  logic             ex_show, ex_append, valid_rec;
  logic [2:0]       ex_status, s_cur;
  logic [REC_W-1:0] ex_word, app_word;
  logic [CW-1:0]    ex_idx;
  logic [2:0]       app_life, app_fail;

  logic [HWS-1:0] o_hw;
  logic [1:0]     o_av;
  logic [2:0]     o_life, o_fail;
  logic           o_rt;

  cls_ram #(.WIDTH(REC_W), .DEPTH(MAX_CPUS), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign {r_hw, r_av, r_life, r_fail, r_rt} = rd_data;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != cls_pkg::FSM_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign topo  = (cc_r == 7'd0) || (32'(cc_r) > MAX_CPUS) || ({1'b0, boot_r} >= cc_r);
  assign full  = 32'(cnt_r) >= 32'(cc_r);
  assign id_ok = 32'(lid_r) < 32'(cnt_r);

  assign scan_match = pend_r && (cmd_r != cls_pkg::CMD_SNAPSHOT) && (r_hw == hw_r);
  assign scan_issue = (iss_r < cnt_r) && !scan_match;
  assign scan_end   = !scan_issue && !pend_r;

  always_comb begin
    start_scan = 1'b0;
    case (cmd_r)
      cls_pkg::CMD_APPEND:
        start_scan = !(done_r || topo || full || av_r == cls_pkg::AV_UNKNOWN);
      cls_pkg::CMD_BY_HW:    start_scan = done_r;
      cls_pkg::CMD_SNAPSHOT: start_scan = 1'b1;
      default:               start_scan = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cls_pkg::FSM_IDLE:  if (in_acc) state_nxt = cls_pkg::FSM_START;
      cls_pkg::FSM_START: state_nxt = start_scan ? cls_pkg::FSM_SCAN : cls_pkg::FSM_EXEC;
      cls_pkg::FSM_SCAN: begin
        if (scan_match) begin
          state_nxt = cls_pkg::FSM_EXEC;
        end else if (scan_end) begin
          state_nxt = (cmd_r == cls_pkg::CMD_SNAPSHOT) ? cls_pkg::FSM_SNAP : cls_pkg::FSM_EXEC;
        end
      end
      cls_pkg::FSM_EXEC:  if (out_free) state_nxt = cls_pkg::FSM_IDLE;
      cls_pkg::FSM_SNAP:  if (out_free && k_r == cls_pkg::LAST_BEAT) state_nxt = cls_pkg::FSM_IDLE;
      default:            state_nxt = cls_pkg::FSM_IDLE;
    endcase
  end

  // execute: decide status and record update from the latched command
  always_comb begin
    app_life = (av_r == cls_pkg::AV_ENABLED)  ? cls_pkg::LC_PRESENT :
               (av_r == cls_pkg::AV_DISABLED) ? cls_pkg::LC_POSSIBLE : cls_pkg::LC_FAILED;
    app_fail = (av_r == cls_pkg::AV_FAILED) ? cls_pkg::FC_FIRMWARE : cls_pkg::FC_NONE;
    app_word = {hw_r, av_r, app_life, app_fail, 1'b0};
    valid_rec = done_r && found_r;
    s_cur     = valid_rec ? r_life : cls_pkg::LC_POSSIBLE;
    ex_status = cls_pkg::STS_OK;
    ex_show   = 1'b0;
    ex_append = 1'b0;
    ex_word   = rd_data;
    ex_idx    = idx_r;
    case (cmd_r)
      cls_pkg::CMD_APPEND: begin
        if (done_r) begin
          ex_status = cls_pkg::STS_DONE;
        end else if (topo || full) begin
          ex_status = cls_pkg::STS_TOPO;
        end else if (av_r == cls_pkg::AV_UNKNOWN) begin
          ex_status = cls_pkg::STS_REJ;
        end else if (found_r) begin
          ex_status = cls_pkg::STS_DUP;
          ex_show   = 1'b1;
        end else begin
          ex_append = 1'b1;
          ex_show   = 1'b1;
          ex_word   = app_word;
          ex_idx    = cnt_r;
        end
      end
      cls_pkg::CMD_FINISH: begin
        if (done_r) begin
          ex_status = cls_pkg::STS_DONE;
        end else if (topo || cnt_r != CW'(cc_r) || r_av != cls_pkg::AV_ENABLED) begin
          ex_status = cls_pkg::STS_TOPO;
        end
      end
      cls_pkg::CMD_RESERVE: begin
        ex_show = found_r;
        if (!valid_rec || r_av != cls_pkg::AV_ENABLED || s_cur != cls_pkg::LC_PRESENT
            || r_rt) begin
          ex_status = cls_pkg::STS_STATE;
        end else if (!alloc_r) begin
          ex_status = cls_pkg::STS_ALLOC;
          ex_word   = {r_hw, r_av, cls_pkg::LC_FAILED, cls_pkg::FC_ALLOC, r_rt};
        end
      end
      cls_pkg::CMD_FAIL_RT: begin
        ex_show = found_r;
        if (!valid_rec || s_cur != cls_pkg::LC_PRESENT || r_rt || fc_r == cls_pkg::FC_NONE) begin
          ex_status = cls_pkg::STS_STATE;
        end else begin
          ex_word = {r_hw, r_av, cls_pkg::LC_FAILED, fc_r, r_rt};
        end
      end
      cls_pkg::CMD_PUBLISH: begin
        ex_show = found_r;
        if (!valid_rec || s_cur != cls_pkg::LC_PRESENT || r_rt) begin
          ex_status = cls_pkg::STS_STATE;
        end else if (!ready_r) begin
          ex_status = cls_pkg::STS_REJ;
        end else begin
          ex_word = {r_hw, r_av, cls_pkg::LC_PREPARED, r_fail, 1'b1};
        end
      end
      cls_pkg::CMD_BEGIN: begin
        ex_show = found_r;
        if (!valid_rec || s_cur != cls_pkg::LC_PREPARED) begin
          ex_status = cls_pkg::STS_REJ;
        end else begin
          ex_word = {r_hw, r_av, cls_pkg::LC_STARTING, r_fail, r_rt};
        end
      end
      cls_pkg::CMD_FAIL_ST: begin
        ex_show = found_r;
        if (fc_r == cls_pkg::FC_NONE || !valid_rec
            || (s_cur != cls_pkg::LC_PREPARED && s_cur != cls_pkg::LC_STARTING)) begin
          ex_status = cls_pkg::STS_REJ;
        end else begin
          ex_word = {r_hw, r_av, cls_pkg::LC_FAILED, fc_r, r_rt};
        end
      end
      cls_pkg::CMD_ONLINE: begin
        ex_show = found_r;
        if (!valid_rec || !r_rt || !ready_r || s_cur != cls_pkg::LC_STARTING) begin
          ex_status = cls_pkg::STS_REJ;
        end else begin
          ex_word = {r_hw, r_av, cls_pkg::LC_ONLINE, r_fail, r_rt};
        end
      end
      cls_pkg::CMD_BY_ID: begin
        ex_show = valid_rec;
        if (!valid_rec) ex_status = cls_pkg::STS_NOTFOUND;
      end
      cls_pkg::CMD_BY_HW: begin
        ex_show = found_r;
        if (!found_r) ex_status = cls_pkg::STS_NOTFOUND;
      end
      default: begin
        ex_status = cls_pkg::STS_REJ;
      end
    endcase
    {o_hw, o_av, o_life, o_fail, o_rt} = ex_word;
  end

  // memory ports and datapath updates
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = '0;
    wr_data   = ex_word;
    iss_nxt   = iss_r;
    pend_nxt  = 1'b0;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    k_nxt     = k_r;
    for (int i = 0; i < 6; i++) snap_nxt[i] = snap_r[i];
    case (state_r)
      cls_pkg::FSM_START: begin
        iss_nxt   = '0;
        found_nxt = 1'b0;
        idx_nxt   = CW'(lid_r);
        k_nxt     = '0;
        for (int i = 0; i < 6; i++) snap_nxt[i] = '0;
        case (cmd_r)
          cls_pkg::CMD_FINISH: begin
            idx_nxt = CW'(boot_r);
            rd_addr = AW'(boot_r);
            rd_en   = !(done_r || topo || cnt_r != CW'(cc_r));
          end
          cls_pkg::CMD_RESERVE, cls_pkg::CMD_FAIL_RT, cls_pkg::CMD_PUBLISH,
          cls_pkg::CMD_BEGIN, cls_pkg::CMD_FAIL_ST, cls_pkg::CMD_ONLINE,
          cls_pkg::CMD_BY_ID: begin
            found_nxt = id_ok;
            rd_addr   = AW'(lid_r);
            rd_en     = id_ok;
          end
          default: begin
            rd_en = 1'b0;
          end
        endcase
      end
      cls_pkg::FSM_SCAN: begin
        // one entry issued and one checked each cycle
        rd_en    = scan_issue;
        rd_addr  = iss_r[AW-1:0];
        pend_nxt = scan_issue;
        if (scan_issue) iss_nxt = iss_r + CW'(1);
        if (scan_match) begin
          found_nxt = 1'b1;
          idx_nxt   = chk_r;
        end
        if (pend_r && cmd_r == cls_pkg::CMD_SNAPSHOT && r_life <= cls_pkg::LC_FAILED) begin
          snap_nxt[r_life] = snap_r[r_life] + CW'(1);
        end
      end
      cls_pkg::FSM_EXEC: begin
        if (out_free) begin
          wr_addr = ex_idx[AW-1:0];
          we      = ex_append || (ex_show && ex_word != rd_data &&
                                  cmd_r != cls_pkg::CMD_APPEND);
          if (ex_append) cnt_nxt = cnt_r + CW'(1);
          if (cmd_r == cls_pkg::CMD_FINISH && !done_r && ex_status == cls_pkg::STS_OK) begin
            done_nxt = 1'b1;
          end
        end
      end
      cls_pkg::FSM_SNAP: begin
        if (out_free) k_nxt = k_r + 3'd1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cls_pkg::FSM_IDLE;
      cc_r        <= 7'd1;
      boot_r      <= 6'd0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we) begin
        if (cfg_index) boot_r <= cfg_wdata[5:0];
        else           cc_r   <= cfg_wdata;
      end
      if ((state_r == cls_pkg::FSM_EXEC || state_r == cls_pkg::FSM_SNAP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_command;
      lid_r   <= in_logical_id;
      hw_r    <= in_hardware_id[HWS-1:0];
      av_r    <= in_availability;
      fc_r    <= in_failure_code;
      alloc_r <= in_alloc_ok;
      ready_r <= in_runtime_ready;
    end
    iss_r   <= iss_nxt;
    chk_r   <= iss_r;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    k_r     <= k_nxt;
    for (int i = 0; i < 6; i++) snap_r[i] <= snap_nxt[i];
    if (state_r == cls_pkg::FSM_EXEC && out_free) begin
      out_status           <= ex_status;
      out_logical_id_res   <= ex_show ? 6'(ex_idx) : 6'd0;
      out_hardware_id_res  <= ex_show ? 32'(o_hw) : 32'd0;
      out_cpu_state        <= ex_show ? o_life : 3'd0;
      out_failure_code_res <= ex_show ? o_fail : 3'd0;
      out_availability_res <= ex_show ? o_av : 2'd0;
      out_runtime_visible  <= ex_show && o_rt && o_life >= cls_pkg::LC_PREPARED
                              && o_life <= cls_pkg::LC_FAILED;
      out_state_count      <= 7'd0;
      out_last             <= 1'b1;
    end else if (state_r == cls_pkg::FSM_SNAP && out_free) begin
      out_status           <= cls_pkg::STS_OK;
      out_logical_id_res   <= 6'd0;
      out_hardware_id_res  <= 32'd0;
      out_cpu_state        <= k_r;
      out_failure_code_res <= 3'd0;
      out_availability_res <= 2'd0;
      out_runtime_visible  <= 1'b0;
      out_state_count      <= 7'(snap_r[k_r]);
      out_last             <= (k_r == cls_pkg::LAST_BEAT);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_CPUS)
    else $error("record count beyond table depth");

  a_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r == cls_pkg::FSM_EXEC)
    else $error("memory write outside execute");

  a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r != '0)
    else $error("build finished with empty table");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (we && ex_append) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("append did not advance count");

  a_no_beat_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cls_pkg::FSM_SNAP) |-> cmd_r == cls_pkg::CMD_SNAPSHOT)
    else $error("snapshot beats for another command");

endmodule
`default_nettype wire

// File: src/cls_ram.sv
// Record memory: one write port, one registered read port.
`default_nettype none
module cls_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sim/tb_cls_pkg.sv
// Register indexes and spare command codes shared by the testbench files.
`timescale 1ns / 1ps
package tb_cls_pkg;

  localparam logic       REG_CPU_COUNT = 1'b0;
  localparam logic       REG_BOOT_CPU  = 1'b1;

  localparam logic [3:0] CMD_BAD_LO    = 4'd11;
  localparam logic [3:0] CMD_BAD_HI    = 4'd15;

endpackage

// File: sim/cls_checker.sv
// Checker: predicts the state table's results and compares them with the block.
`timescale 1ns / 1ps
module cls_checker
  import cls_pkg::*;
  import tb_cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic [5:0]  in_logical_id,
  input  logic [31:0] in_hardware_id,
  input  logic [1:0]  in_availability,
  input  logic [2:0]  in_failure_code,
  input  logic        in_alloc_ok,
  input  logic        in_runtime_ready,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [5:0]  out_logical_id_res,
  input  logic [31:0] out_hardware_id_res,
  input  logic [2:0]  out_cpu_state,
  input  logic [2:0]  out_failure_code_res,
  input  logic [1:0]  out_availability_res,
  input  logic        out_runtime_visible,
  input  logic [6:0]  out_state_count,
  input  logic        out_last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  lid;
    logic [31:0] hw;
    logic [2:0]  lc;
    logic [2:0]  fc;
    logic [1:0]  av;
    logic        vis;
    logic [6:0]  cnt;
    logic        last;
  } beat_t;

  beat_t       answers_q[$];
  logic [31:0] hw_tab[64];
  logic [1:0]  av_tab[64];
  logic [2:0]  lc_tab[64];
  logic [2:0]  fc_tab[64];
  logic        rt_tab[64];
  int          n_rec;
  bit          built;
  logic [6:0]  cpu_cnt;
  logic [5:0]  boot_cpu;

  function automatic beat_t record_beat(logic [2:0] status, int idx, logic last);
    beat_t b;
    b = '0;
    b.status = status;
    if (idx >= 0 && idx < n_rec) begin
      b.lid = idx[5:0];
      b.hw  = hw_tab[idx];
      b.lc  = lc_tab[idx];
      b.fc  = fc_tab[idx];
      b.av  = av_tab[idx];
      b.vis = rt_tab[idx] && lc_tab[idx] >= LC_PREPARED && lc_tab[idx] <= LC_FAILED;
    end
    b.last = last;
    return b;
  endfunction

  function automatic bit topology_bad();
    return cpu_cnt == 0 || cpu_cnt > 64 || {1'b0, boot_cpu} >= cpu_cnt;
  endfunction

  function automatic int find_hw(logic [31:0] hw);
    for (int i = 0; i < n_rec; i++)
      if (hw_tab[i] == hw) return i;
    return -1;
  endfunction

  task automatic predict_table(logic [3:0] cmd, logic [5:0] id, logic [31:0] hw,
                               logic [1:0] av, logic [2:0] fc, logic ao, logic rr);
    bit         live;
    int         rec;
    int         d;
    logic [2:0] s;
    int         cnt[6];
    beat_t      b;
    live = built && id < n_rec;
    rec  = (id < n_rec) ? int'(id) : -1;
    s    = live ? lc_tab[id] : LC_POSSIBLE;
    case (cmd)
      CMD_APPEND: begin
        if (built) answers_q.push_back(record_beat(STS_DONE, -1, 1));
        else if (topology_bad() || n_rec >= cpu_cnt)
          answers_q.push_back(record_beat(STS_TOPO, -1, 1));
        else if (av == AV_UNKNOWN) answers_q.push_back(record_beat(STS_REJ, -1, 1));
        else begin
          d = find_hw(hw);
          if (d >= 0) answers_q.push_back(record_beat(STS_DUP, d, 1));
          else begin
            hw_tab[n_rec] = hw;
            av_tab[n_rec] = av;
            rt_tab[n_rec] = 1'b0;
            fc_tab[n_rec] = (av == AV_FAILED) ? FC_FIRMWARE : FC_NONE;
            lc_tab[n_rec] = (av == AV_ENABLED) ? LC_PRESENT :
                            (av == AV_DISABLED) ? LC_POSSIBLE : LC_FAILED;
            n_rec++;
            answers_q.push_back(record_beat(STS_OK, n_rec - 1, 1));
          end
        end
      end
      CMD_FINISH: begin
        if (built) answers_q.push_back(record_beat(STS_DONE, -1, 1));
        else if (topology_bad() || n_rec != cpu_cnt || boot_cpu >= n_rec ||
                 av_tab[boot_cpu] != AV_ENABLED)
          answers_q.push_back(record_beat(STS_TOPO, -1, 1));
        else begin
          built = 1'b1;
          answers_q.push_back(record_beat(STS_OK, -1, 1));
        end
      end
      CMD_RESERVE: begin
        if (!live || av_tab[id] != AV_ENABLED || s != LC_PRESENT || rt_tab[id])
          answers_q.push_back(record_beat(STS_STATE, rec, 1));
        else if (!ao) begin
          fc_tab[id] = FC_ALLOC;
          lc_tab[id] = LC_FAILED;
          answers_q.push_back(record_beat(STS_ALLOC, rec, 1));
        end else answers_q.push_back(record_beat(STS_OK, rec, 1));
      end
      CMD_FAIL_RT: begin
        if (!live || s != LC_PRESENT || rt_tab[id] || fc == FC_NONE)
          answers_q.push_back(record_beat(STS_STATE, rec, 1));
        else begin
          fc_tab[id] = fc;
          lc_tab[id] = LC_FAILED;
          answers_q.push_back(record_beat(STS_OK, rec, 1));
        end
      end
      CMD_PUBLISH: begin
        if (!live || s != LC_PRESENT || rt_tab[id])
          answers_q.push_back(record_beat(STS_STATE, rec, 1));
        else if (!rr) answers_q.push_back(record_beat(STS_REJ, rec, 1));
        else begin
          rt_tab[id] = 1'b1;
          lc_tab[id] = LC_PREPARED;
          answers_q.push_back(record_beat(STS_OK, rec, 1));
        end
      end
      CMD_BEGIN: begin
        if (!live || s != LC_PREPARED) answers_q.push_back(record_beat(STS_REJ, rec, 1));
        else begin
          lc_tab[id] = LC_STARTING;
          answers_q.push_back(record_beat(STS_OK, rec, 1));
        end
      end
      CMD_FAIL_ST: begin
        if (fc == FC_NONE || !live || (s != LC_PREPARED && s != LC_STARTING))
          answers_q.push_back(record_beat(STS_REJ, rec, 1));
        else begin
          fc_tab[id] = fc;
          lc_tab[id] = LC_FAILED;
          answers_q.push_back(record_beat(STS_OK, rec, 1));
        end
      end
      CMD_ONLINE: begin
        if (!live || !rt_tab[id] || !rr || s != LC_STARTING)
          answers_q.push_back(record_beat(STS_REJ, rec, 1));
        else begin
          lc_tab[id] = LC_ONLINE;
          answers_q.push_back(record_beat(STS_OK, rec, 1));
        end
      end
      CMD_BY_ID: begin
        if (!live) answers_q.push_back(record_beat(STS_NOTFOUND, -1, 1));
        else answers_q.push_back(record_beat(STS_OK, rec, 1));
      end
      CMD_BY_HW: begin
        d = built ? find_hw(hw) : -1;
        answers_q.push_back(record_beat(d >= 0 ? STS_OK : STS_NOTFOUND, d, 1));
      end
      CMD_SNAPSHOT: begin
        foreach (cnt[k]) cnt[k] = 0;
        for (int i = 0; i < n_rec; i++)
          if (lc_tab[i] <= LC_FAILED) cnt[lc_tab[i]]++;
        for (int k = 0; k < 6; k++) begin
          b = record_beat(STS_OK, -1, k == LAST_BEAT);
          b.lc  = k[2:0];
          b.cnt = cnt[k][6:0];
          answers_q.push_back(b);
        end
      end
      default: answers_q.push_back(record_beat(STS_REJ, -1, 1));
    endcase
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst_n) begin
      answers_q.delete();
      foreach (hw_tab[i]) begin
        hw_tab[i] = '0;
        av_tab[i] = '0;
        lc_tab[i] = '0;
        fc_tab[i] = '0;
        rt_tab[i] = 1'b0;
      end
      n_rec    = 0;
      built    = 1'b0;
      cpu_cnt  = 7'd1;
      boot_cpu = 6'd0;
      errors   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_logical_id_res, out_hardware_id_res, out_cpu_state,
                out_failure_code_res, out_availability_res, out_runtime_visible,
                out_state_count, out_last};
        if (answers_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = answers_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: sts %0d/%0d lid %0d/%0d hw %h/%h st %0d/%0d fc %0d/%0d av %0d/%0d vis %0d/%0d cnt %0d/%0d last %0d/%0d (exp/act)",
                       want.status, got.status, want.lid, got.lid, want.hw, got.hw,
                       want.lc, got.lc, want.fc, got.fc, want.av, got.av,
                       want.vis, got.vis, want.cnt, got.cnt, want.last, got.last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_CPU_COUNT) cpu_cnt = cfg_wdata;
        else boot_cpu = cfg_wdata[5:0];
      end
      if (in_valid && !in_stall)
        predict_table(in_command, in_logical_id, in_hardware_id, in_availability,
                      in_failure_code, in_alloc_ok, in_runtime_ready);
    end
    pending = answers_q.size();
  end

endmodule

// File: sim/tb.sv
// Top of the state table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import cls_pkg::*;
  import tb_cls_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_command = '0;
  logic [5:0]  in_logical_id = '0;
  logic [31:0] in_hardware_id = '0;
  logic [1:0]  in_availability = '0;
  logic [2:0]  in_failure_code = '0;
  logic        in_alloc_ok = 1'b0;
  logic        in_runtime_ready = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [5:0]  out_logical_id_res;
  logic [31:0] out_hardware_id_res;
  logic [2:0]  out_cpu_state;
  logic [2:0]  out_failure_code_res;
  logic [1:0]  out_availability_res;
  logic        out_runtime_visible;
  logic [6:0]  out_state_count;
  logic        out_last;
  int          errors;
  int          pending;

  int          snd_idle = 17;
  int          rcv_idle = 85;
  int          n_sent = 0;
  int          quiet = 0;
  logic [31:0] known_hw[$];
  logic [1:0]  known_av[$];

  always #2 clk = ~clk;

  cpu_lifecycle_state_table u_top (.*);

  cls_checker u_chk (.*);

  always @(posedge clk)
    out_stall <= (rcv_idle > 0) && ($urandom_range(99) < rcv_idle);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_cmd(logic [3:0] cmd, logic [5:0] id, logic [31:0] hw,
                          logic [1:0] av, logic [2:0] fc, logic ao, logic rr);
    // swap the idle pattern by thirds of the run
    if (n_sent < 105) begin
      snd_idle = 17;
      rcv_idle = 85;
    end else if (n_sent < 210) begin
      snd_idle = 85;
      rcv_idle = 17;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_command       <= cmd;
    in_logical_id    <= id;
    in_hardware_id   <= hw;
    in_availability  <= av;
    in_failure_code  <= fc;
    in_alloc_ok      <= ao;
    in_runtime_ready <= rr;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic send_noise();
    send_cmd($urandom_range(15), $urandom_range(63), $urandom, $urandom_range(3),
             $urandom_range(7), $urandom_range(1), $urandom_range(1));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // drop the enable after each write so back-to-back writes stay apart
  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit hw_known(logic [31:0] hw);
    foreach (known_hw[i]) if (known_hw[i] == hw) return 1'b1;
    return 1'b0;
  endfunction

  initial begin
    int          r;
    int          id;
    int          dis;
    logic [31:0] hw;
    logic [1:0]  av;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, default topology
    send_cmd(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_BY_ID, 6'd63, 0, 0, 0, 1, 1);
    send_cmd(CMD_BY_HW, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_cmd(CMD_RESERVE, 0, 0, 0, 0, 1, 1);
    send_cmd(CMD_FAIL_RT, 0, 0, 0, 3'd7, 1, 1);
    send_cmd(CMD_PUBLISH, 0, 0, 0, 0, 1, 1);
    send_cmd(CMD_BEGIN, 0, 0, 0, 0, 1, 1);
    send_cmd(CMD_FAIL_ST, 0, 0, 0, 3'd7, 1, 1);
    send_cmd(CMD_ONLINE, 0, 0, 0, 0, 1, 1);
    send_cmd(CMD_BAD_LO, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_BAD_HI, 6'd63, 32'hFFFF_FFFF, AV_UNKNOWN, 3'd7, 1, 1);
    send_cmd(CMD_APPEND, 0, 32'h1234_5678, AV_UNKNOWN, 0, 0, 0);
    drain();

    // topology out of range: zero count, count far too big, boot not below count
    write_reg(REG_CPU_COUNT, 7'd0);
    drain();
    send_cmd(CMD_APPEND, 0, 32'h1, AV_ENABLED, 0, 0, 0);
    send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
    drain();
    write_reg(REG_CPU_COUNT, 7'd127);
    drain();
    send_cmd(CMD_APPEND, 0, 32'h1, AV_ENABLED, 0, 0, 0);
    drain();
    write_reg(REG_CPU_COUNT, 7'd4);
    write_reg(REG_BOOT_CPU, 6'd5);
    drain();
    send_cmd(CMD_APPEND, 0, 32'h1, AV_ENABLED, 0, 0, 0);
    drain();

    // full build of 64 records with the boot CPU at the top
    write_reg(REG_CPU_COUNT, 7'd64);
    write_reg(REG_BOOT_CPU, 6'd63);
    drain();
    while (known_hw.size() < 64) begin
      r = $urandom_range(99);
      if (known_hw.size() == 0 || known_hw.size() == 1) begin
        hw = known_hw.size() == 0 ? 32'h0 : 32'hFFFF_FFFF;
        send_cmd(CMD_APPEND, $urandom_range(63), hw, AV_ENABLED, $urandom_range(7),
                 $urandom_range(1), $urandom_range(1));
        known_hw.push_back(hw);
        known_av.push_back(AV_ENABLED);
      end else if (r < 6) begin
        send_cmd(CMD_APPEND, $urandom_range(63), known_hw[$urandom_range(known_hw.size() - 1)],
                 $urandom_range(2), $urandom_range(7), $urandom_range(1), $urandom_range(1));
      end else if (r < 9) begin
        send_cmd(CMD_APPEND, $urandom_range(63), $urandom, AV_UNKNOWN, $urandom_range(7),
                 $urandom_range(1), $urandom_range(1));
      end else if (r < 12) begin
        send_cmd(CMD_FINISH, $urandom_range(63), $urandom, 0, 0, 0, 0);
      end else if (r < 16) begin
        send_noise();
      end else begin
        do hw = $urandom; while (hw_known(hw));
        if (known_hw.size() == 63) av = AV_ENABLED;
        else begin
          r = $urandom_range(99);
          av = r < 70 ? AV_ENABLED : r < 85 ? AV_DISABLED : AV_FAILED;
        end
        // a clash with a stored id turns the append into a duplicate
        send_cmd(CMD_APPEND, $urandom_range(63), hw, av, $urandom_range(7),
                 $urandom_range(1), $urandom_range(1));
        known_hw.push_back(hw);
        known_av.push_back(av);
      end
    end
    send_cmd(CMD_APPEND, 0, 32'h5A5A_A5A5, AV_ENABLED, 0, 0, 0);
    send_cmd(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0);
    drain();

    // finish refused while the boot CPU is not enabled
    dis = -1;
    foreach (known_av[i]) if (known_av[i] != AV_ENABLED && dis < 0) dis = i;
    if (dis >= 0) begin
      write_reg(REG_BOOT_CPU, dis[5:0]);
      drain();
      send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
      drain();
    end
    write_reg(REG_BOOT_CPU, 6'd63);
    drain();
    send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_FINISH, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_APPEND, 0, 32'h7777_0000, AV_ENABLED, 0, 0, 0);

    // bring-up flows with random content, mixed with lookups and noise
    while (n_sent < 310) begin
      r = $urandom_range(99);
      if (r < 55) begin
        id = $urandom_range(63);
        send_cmd(CMD_RESERVE, id, $urandom, $urandom_range(3), $urandom_range(7),
                 $urandom_range(9) != 0, $urandom_range(1));
        if ($urandom_range(9) == 0)
          send_cmd(CMD_FAIL_RT, id, $urandom, $urandom_range(3), $urandom_range(7),
                   $urandom_range(1), $urandom_range(1));
        send_cmd(CMD_PUBLISH, id, $urandom, $urandom_range(3), $urandom_range(7),
                 $urandom_range(1), $urandom_range(9) != 0);
        send_cmd(CMD_BEGIN, id, $urandom, $urandom_range(3), $urandom_range(7),
                 $urandom_range(1), $urandom_range(1));
        if ($urandom_range(3) == 0)
          send_cmd(CMD_FAIL_ST, id, $urandom, $urandom_range(3), $urandom_range(7),
                   $urandom_range(1), $urandom_range(1));
        else
          send_cmd(CMD_ONLINE, id, $urandom, $urandom_range(3), $urandom_range(7),
                   $urandom_range(1), $urandom_range(9) != 0);
      end else if (r < 70) begin
        hw = $urandom_range(3) == 0 ? $urandom : known_hw[$urandom_range(63)];
        send_cmd(CMD_BY_HW, $urandom_range(63), hw, $urandom_range(3), $urandom_range(7),
                 $urandom_range(1), $urandom_range(1));
      end else if (r < 80) begin
        send_cmd(CMD_BY_ID, $urandom_range(63), $urandom, $urandom_range(3),
                 $urandom_range(7), $urandom_range(1), $urandom_range(1));
      end else if (r < 86) begin
        send_cmd(CMD_SNAPSHOT, $urandom_range(63), $urandom, $urandom_range(3),
                 $urandom_range(7), $urandom_range(1), $urandom_range(1));
      end else begin
        send_noise();
      end
    end
    send_cmd(CMD_SNAPSHOT, 0, 0, 0, 0, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
src/cls_pkg.sv
src/cls_ram.sv
src/cpu_lifecycle_state_table.sv
sim/tb_cls_pkg.sv
sim/cls_checker.sv
sim/tb.sv
